// ===== design/bst_pkg.sv =====
// Shared types and constants of the backend slot table.
package bst_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int MAX_RESULTS    = 16;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_SET_HLTH  = 3'd2,
        OP_SET_MAC   = 3'd3,
        OP_SNAP_ELIG = 3'd4,
        OP_SNAP_ALL  = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] backend_addr;
        logic [15:0] backend_port;
        logic [31:0] target_id;
        logic        health_flag;
        logic [47:0] mac_value;
        logic [4:0]  snapshot_cap;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        changed;
        logic [31:0] assigned_id;
        logic        entry_valid;
        logic [31:0] entry_id;
        logic [31:0] entry_addr;
        logic [15:0] entry_port;
        logic [47:0] entry_mac;
        logic        entry_healthy;
        logic        entry_mac_known;
        logic [4:0]  entry_count;
        logic        last;
    } t_rsp;

endpackage

// ===== design/bst_req_if.sv =====
// Valid/ready channel carrying one request.
interface bst_req_if;
    logic          valid;
    logic          ready;
    bst_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/bst_rsp_if.sv =====
// Valid/ready channel carrying one result.
interface bst_rsp_if;
    logic          valid;
    logic          ready;
    bst_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/backend_slot_table_unit.sv =====
// Backend slot table: top level with slot memories and scan sequencer.
//
// Usage: requests arrive on i_req (add, remove, set health, set MAC and the
// two snapshots); results leave on o_rsp. Every request gives one result,
// except a snapshot, which gives one result per listed entry (at most the
// clipped cap) and a single empty result when nothing is listed. The last
// result of a request carries last = 1.
// One request is handled at a time: i_req.ready is high only while the
// sequencer is idle. The sequencer walks the slots one per cycle through a
// single compare stage behind a registered memory read, and stops early when
// the target slot is found. A snapshot resumes the walk at the next slot
// after each listed entry is taken. Unused opcodes and a snapshot with a cap
// of zero answer in the cycle after acceptance, without a walk.
// A result waits in the output register while o_rsp.ready is low; the walk
// pauses until it is taken.
// Reset clears all slot-used bits, the id counter and the sequencer; slot
// contents are not cleared and are read only after an add wrote them.
module backend_slot_table_unit #(
    parameter int SLOT_COUNT = bst_pkg::SLOT_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bst_req_if.sink      i_req,
    bst_rsp_if.source    o_rsp
);
    import bst_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW:0] LAST_IDX = (IW+1)'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;

    // Captured request.
    t_opcode     r_op;
    logic [31:0] r_addr;
    logic [15:0] r_port;
    logic [31:0] r_tid;
    logic        r_hflag;
    logic [47:0] r_mac;
    logic [4:0]  r_cap;

    // Slot state.
    logic [SLOT_COUNT-1:0] r_busy;
    logic [SLOT_COUNT-1:0] r_health;
    logic [SLOT_COUNT-1:0] r_mac_known;
    logic [31:0]           r_id_ctr;
    logic [31:0]           r_mem_id   [SLOT_COUNT];
    logic [31:0]           r_mem_addr [SLOT_COUNT];
    logic [15:0]           r_mem_port [SLOT_COUNT];
    logic [47:0]           r_mem_mac  [SLOT_COUNT];

    // Scan pipeline: issue index, registered read, compare.
    logic [IW:0]   r_idx;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [31:0]   r_rd_id;
    logic [31:0]   r_rd_addr;
    logic [15:0]   r_rd_port;
    logic [47:0]   r_rd_mac;
    logic [4:0]    r_count;

    t_rsp r_rsp;
    t_rsp n_rsp;
    logic r_out_vld;

    // Memory write port.
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic          wr_full;
    logic          wr_mac_only;

    logic                  slot_busy;
    logic                  id_hit;
    logic                  snap_hit;
    logic                  hit;
    logic                  scan_end;
    logic [SLOT_COUNT-1:0] elig;
    logic [SLOT_COUNT-1:0] above;
    logic                  more_elig;
    logic [4:0]            n_count;
    logic [4:0]            cap_clip;
    logic                  req_acc;
    logic                  rsp_acc;

    assign req_acc = i_req.valid && i_req.ready;
    assign rsp_acc = o_rsp.valid && o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_rsp;

    assign cap_clip = (i_req.data.snapshot_cap > 5'(MAX_RESULTS)) ?
                      5'(MAX_RESULTS) : i_req.data.snapshot_cap;

    // Compare stage: one slot per cycle.
    always_comb begin
        slot_busy = r_busy[r_rd_idx];
        id_hit    = slot_busy && (r_rd_id == r_tid);
        snap_hit  = slot_busy &&
                    ((r_op == OP_SNAP_ALL) || (r_health[r_rd_idx] && r_mac_known[r_rd_idx]));
        case (r_op)
            OP_ADD:                   hit = !slot_busy;
            OP_REMOVE, OP_SET_HLTH,
            OP_SET_MAC:               hit = id_hit;
            OP_SNAP_ELIG, OP_SNAP_ALL: hit = snap_hit;
            default:                  hit = 1'b0;
        endcase
        hit      = hit && r_rd_vld && (r_state == S_SCAN);
        scan_end = r_rd_vld && (r_state == S_SCAN) && !hit &&
                   ({1'b0, r_rd_idx} == LAST_IDX);
        n_count  = r_count + 5'd1;
    end

    // Eligible entries beyond the current slot; with the cap, they decide the last flag.
    always_comb begin
        for (int j = 0; j < SLOT_COUNT; j++) begin
            elig[j]  = r_busy[j] &&
                       ((r_op == OP_SNAP_ALL) || (r_health[j] && r_mac_known[j]));
            above[j] = (IW'(j) > r_rd_idx);
        end
        more_elig = |(elig & above);
    end

    // Next result: an empty last result unless the scan hit, or ran out on an add, remove or set.
    always_comb begin
        n_rsp      = '0;
        n_rsp.last = 1'b1;
        if (hit) begin
            case (r_op)
                OP_ADD: begin
                    n_rsp.changed     = 1'b1;
                    n_rsp.assigned_id = r_id_ctr;
                end
                OP_REMOVE: begin
                    n_rsp.changed = 1'b1;
                end
                OP_SET_HLTH: begin
                    n_rsp.changed = (r_health[r_rd_idx] != r_hflag);
                end
                OP_SET_MAC: begin
                    n_rsp.changed = 1'b1;
                end
                OP_SNAP_ELIG, OP_SNAP_ALL: begin
                    n_rsp.entry_valid     = 1'b1;
                    n_rsp.entry_id        = r_rd_id;
                    n_rsp.entry_addr      = r_rd_addr;
                    n_rsp.entry_port      = r_rd_port;
                    n_rsp.entry_mac       = r_rd_mac;
                    n_rsp.entry_healthy   = r_health[r_rd_idx];
                    n_rsp.entry_mac_known = r_mac_known[r_rd_idx];
                    n_rsp.entry_count     = n_count;
                    n_rsp.last            = (n_count == r_cap) || !more_elig;
                end
                default: begin
                    n_rsp.changed = 1'b0;
                end
            endcase
        end else if (scan_end) begin
            if (r_op == OP_ADD) begin
                n_rsp.status      = ST_FULL;
                n_rsp.assigned_id = '1;
            end else if (r_op == OP_REMOVE || r_op == OP_SET_HLTH ||
                         r_op == OP_SET_MAC) begin
                n_rsp.status = ST_NOT_FOUND;
            end
        end
    end

    always_comb begin
        wr_en       = hit && ((r_op == OP_ADD) || (r_op == OP_SET_MAC));
        wr_idx      = r_rd_idx;
        wr_mac_only = (r_op == OP_SET_MAC);
        wr_full     = (r_op == OP_ADD);
    end

    // Slot memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en && wr_full) begin
            r_mem_id[wr_idx]   <= r_id_ctr;
            r_mem_addr[wr_idx] <= r_addr;
            r_mem_port[wr_idx] <= r_port;
            r_mem_mac[wr_idx]  <= '0;
        end else if (wr_en && wr_mac_only) begin
            r_mem_mac[wr_idx]  <= r_mac;
        end
        r_rd_id   <= r_mem_id[r_idx[IW-1:0]];
        r_rd_addr <= r_mem_addr[r_idx[IW-1:0]];
        r_rd_port <= r_mem_port[r_idx[IW-1:0]];
        r_rd_mac  <= r_mem_mac[r_idx[IW-1:0]];
        r_rd_idx  <= r_idx[IW-1:0];
    end

    // Flag bits without reset; only read behind a busy bit.
    always_ff @(posedge i_clk) begin
        if (hit && (r_op == OP_ADD)) begin
            r_health[r_rd_idx]    <= 1'b1;
            r_mac_known[r_rd_idx] <= 1'b0;
        end else if (hit && (r_op == OP_SET_HLTH)) begin
            r_health[r_rd_idx]    <= r_hflag;
        end else if (hit && (r_op == OP_SET_MAC)) begin
            r_mac_known[r_rd_idx] <= 1'b1;
        end
    end

    // Captured request payload.
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_op    <= t_opcode'(i_req.data.opcode);
            r_addr  <= i_req.data.backend_addr;
            r_port  <= i_req.data.backend_port;
            r_tid   <= i_req.data.target_id;
            r_hflag <= i_req.data.health_flag;
            r_mac   <= i_req.data.mac_value;
            r_cap   <= cap_clip;
        end
    end

    // Sequencer, scan control, result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= '0;
            r_id_ctr  <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_idx    <= '0;
                    r_rd_vld <= 1'b0;
                    r_count  <= '0;
                    if (req_acc) begin
                        r_rsp <= n_rsp;
                        if (i_req.data.opcode > 3'(OP_SNAP_ALL) ||
                            ((i_req.data.opcode == 3'(OP_SNAP_ELIG) ||
                              i_req.data.opcode == 3'(OP_SNAP_ALL)) && cap_clip == 5'd0)) begin
                            r_out_vld <= 1'b1;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_rd_vld  <= 1'b0;
                        r_idx     <= {1'b0, r_rd_idx} + 1'b1;
                        r_out_vld <= 1'b1;
                        r_state   <= S_OUT;
                        r_rsp     <= n_rsp;
                        case (r_op)
                            OP_ADD: begin
                                r_busy[r_rd_idx] <= 1'b1;
                                r_id_ctr         <= r_id_ctr + 32'd1;
                            end
                            OP_REMOVE: begin
                                r_busy[r_rd_idx] <= 1'b0;
                            end
                            OP_SNAP_ELIG, OP_SNAP_ALL: begin
                                r_count <= n_count;
                            end
                            default: begin
                            end
                        endcase
                    end else if (scan_end) begin
                        r_rd_vld  <= 1'b0;
                        r_out_vld <= 1'b1;
                        r_state   <= S_OUT;
                        r_rsp     <= n_rsp;
                    end else if (r_idx <= LAST_IDX) begin
                        r_rd_vld <= 1'b1;
                        r_idx    <= r_idx + 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                end
                S_OUT: begin
                    if (rsp_acc) begin
                        r_out_vld <= 1'b0;
                        r_state   <= r_rsp.last ? S_IDLE : S_SCAN;
                    end
                end
                default: begin
                    r_state   <= S_IDLE;
                    r_out_vld <= 1'b0;
                end
            endcase
        end
    end

    // A result is only offered outside the idle state.
    a_idle_no_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_rsp.valid)
        else $error("result offered while idle");

    // A listed entry always has a nonzero running count.
    a_entry_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.entry_valid) |-> (o_rsp.data.entry_count != 5'd0))
        else $error("listed entry with zero count");

    // A full table answers with the all-ones id.
    a_full_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.status == ST_FULL) |-> (o_rsp.data.assigned_id == '1))
        else $error("full status without all-ones id");

    // After a request is taken, no other is taken in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !i_req.ready)
        else $error("second request accepted while busy");

endmodule
